>>> rtl/core/dmm_pkg.sv
// ----------------------------------------------------------------------------
// dmm_pkg
// Shared types, codes and defaults of the dense matrix multiply unit.
// ----------------------------------------------------------------------------
package dmm_pkg;

   localparam int DMM_MAX_ROWS  = 64;
   localparam int DMM_MAX_INNER = 32;
   localparam int DMM_MAX_COLS  = 32;

   localparam int DMM_DATA_W = 32;
   localparam int DMM_PROD_W = 64;

   typedef enum logic [1:0] {
      OP_WRITE_LEFT  = 2'd0,
      OP_WRITE_RIGHT = 2'd1,
      OP_READ        = 2'd2,
      OP_NOP         = 2'd3
   } dmm_opcode_type;

   typedef enum logic [1:0] {
      REG_ROW_COUNT   = 2'd0,
      REG_INNER_COUNT = 2'd1,
      REG_COL_COUNT   = 2'd2,
      REG_UNUSED      = 2'd3
   } dmm_reg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } dmm_state_type;

   // store write request broadcast to the cells
   typedef struct packed {
      logic left;
      logic right;
   } dmm_wr_type;

   // per-cell control decoded from the broadcast
   typedef struct packed {
      logic we_left;
      logic we_right;
      logic active;
   } dmm_cell_ctl_type;

   // zero reads as one, anything above the maximum reads as the maximum
   function automatic logic [6:0] clamp_size(logic [6:0] v, int top);
      logic [6:0] r;
      r = v;
      if (v == 7'd0) begin
         r = 7'd1;
      end else if (32'(v) > top) begin
         r = 7'(top);
      end
      return r;
   endfunction

endpackage

>>> rtl/core/dmm_cell.sv
// ----------------------------------------------------------------------------
// dmm_cell
// One inner-dimension slice: holds column j of A and row j of B, multiplies
// the operands picked by the passing token and adds the product to the
// partial sum handed over by the previous cell.
// ----------------------------------------------------------------------------
module dmm_cell
   import dmm_pkg::*;
#(
   parameter int MAX_ROWS = DMM_MAX_ROWS,
   parameter int MAX_COLS = DMM_MAX_COLS,
   parameter int SUM_W    = 70,
   localparam int RA_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
   localparam int CA_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  dmm_cell_ctl_type             ctl,
   input  logic [RA_W-1:0]              wr_row,
   input  logic [CA_W-1:0]              wr_col,
   input  logic signed [DMM_DATA_W-1:0] wr_data,
   input  logic                         tok_vld_in,
   input  logic [RA_W-1:0]              tok_row_in,
   input  logic [CA_W-1:0]              tok_col_in,
   input  logic signed [SUM_W-1:0]      sum_in,
   output logic                         tok_vld_out,
   output logic [RA_W-1:0]              tok_row_out,
   output logic [CA_W-1:0]              tok_col_out,
   output logic signed [SUM_W-1:0]      sum_out
);

   logic signed [DMM_DATA_W-1:0] left_mem [MAX_ROWS];
   logic signed [DMM_DATA_W-1:0] right_mem [MAX_COLS];

   logic signed [DMM_DATA_W-1:0] a_ff;
   logic signed [DMM_DATA_W-1:0] b_ff;
   logic signed [DMM_PROD_W-1:0] prod_ff;
   logic                         vld1_ff;
   logic                         use2_ff;
   logic [RA_W-1:0]              row1_ff;
   logic [CA_W-1:0]              col1_ff;
   logic signed [SUM_W-1:0]      sum_ff;
   logic signed [SUM_W-1:0]      sum_in_add;

   always_ff @(posedge clock) begin
      if (ctl.we_left) begin
         left_mem[wr_row] <= wr_data;
      end
      if (ctl.we_right) begin
         right_mem[wr_col] <= wr_data;
      end
      a_ff <= left_mem[tok_row_in];
      b_ff <= right_mem[tok_col_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         use2_ff <= 1'b0;
      end else begin
         vld1_ff <= tok_vld_in;
         use2_ff <= vld1_ff & ctl.active;
      end
   end

   // cells past the configured inner length add nothing
   assign sum_in_add = use2_ff ? SUM_W'(prod_ff) : '0;

   always_ff @(posedge clock) begin
      row1_ff <= tok_row_in;
      col1_ff <= tok_col_in;
      prod_ff <= a_ff * b_ff;
      sum_ff  <= sum_in + sum_in_add;
   end

   assign tok_vld_out = vld1_ff;
   assign tok_row_out = row1_ff;
   assign tok_col_out = col1_ff;
   assign sum_out     = sum_ff;

endmodule

>>> rtl/core/dmm_chain.sv
// ----------------------------------------------------------------------------
// dmm_chain
// Row of MAX_INNER cells. Decodes the store write broadcast into per-cell
// enables and passes the read token and the partial sum down the row.
// ----------------------------------------------------------------------------
module dmm_chain
   import dmm_pkg::*;
#(
   parameter int MAX_ROWS  = DMM_MAX_ROWS,
   parameter int MAX_INNER = DMM_MAX_INNER,
   parameter int MAX_COLS  = DMM_MAX_COLS,
   parameter int SUM_W     = 70
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [5:0]                   inner_count,
   input  dmm_wr_type                   wr,
   input  logic [5:0]                   wr_row,
   input  logic [4:0]                   wr_col,
   input  logic signed [DMM_DATA_W-1:0] wr_data,
   input  logic                         tok_vld,
   input  logic [5:0]                   tok_row,
   input  logic [4:0]                   tok_col,
   output logic                         sum_vld,
   output logic signed [SUM_W-1:0]      sum
);

   localparam int RA_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CA_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

   logic                    vld_link [MAX_INNER+1];
   logic [RA_W-1:0]         row_link [MAX_INNER+1];
   logic [CA_W-1:0]         col_link [MAX_INNER+1];
   logic signed [SUM_W-1:0] sum_link [MAX_INNER+1];
   dmm_cell_ctl_type        ctl [MAX_INNER];
   logic [RA_W-1:0]         wr_row_addr;
   logic [CA_W-1:0]         wr_col_addr;
   logic                    done1_ff;
   logic                    done2_ff;

   assign wr_row_addr = RA_W'(wr_row);
   assign wr_col_addr = CA_W'(wr_col);

   assign vld_link[0] = tok_vld;
   assign row_link[0] = RA_W'(tok_row);
   assign col_link[0] = CA_W'(tok_col);
   assign sum_link[0] = '0;

   for (genvar j = 0; j < MAX_INNER; j++) begin : g_cell
      // A(r,j) lives in cell j at address r, B(j,c) in cell j at address c
      assign ctl[j].we_left  = wr.left  & (32'(wr_col) == 32'(j));
      assign ctl[j].we_right = wr.right & (32'(wr_row) == 32'(j));
      assign ctl[j].active   = 32'(inner_count) > 32'(j);

      dmm_cell #(
         .MAX_ROWS (MAX_ROWS),
         .MAX_COLS (MAX_COLS),
         .SUM_W    (SUM_W)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl[j]),
         .wr_row      (wr_row_addr),
         .wr_col      (wr_col_addr),
         .wr_data     (wr_data),
         .tok_vld_in  (vld_link[j]),
         .tok_row_in  (row_link[j]),
         .tok_col_in  (col_link[j]),
         .sum_in      (sum_link[j]),
         .tok_vld_out (vld_link[j+1]),
         .tok_row_out (row_link[j+1]),
         .tok_col_out (col_link[j+1]),
         .sum_out     (sum_link[j+1])
      );
   end

   // the sum leaves the last cell behind its token, so done1_ff and done2_ff delay its valid
   always_ff @(posedge clock) begin
      if (reset) begin
         done1_ff <= 1'b0;
         done2_ff <= 1'b0;
      end else begin
         done1_ff <= vld_link[MAX_INNER];
         done2_ff <= done1_ff;
      end
   end

   assign sum_vld = done2_ff;
   assign sum     = sum_link[MAX_INNER];

endmodule

>>> rtl/core/dense_matrix_multiply_unit.sv
// ----------------------------------------------------------------------------
// dense_matrix_multiply_unit
// Dense C = A x B on signed Q16.16 values, with A and B held in a row of cells.
// ----------------------------------------------------------------------------
// Write beats load A(row,col) or B(row,col); writes outside the configured
// sizes are dropped. A read beat for C(row,col) sends a token down a chain
// of MAX_INNER cells, one cell per cycle, each adding A(row,j)*B(j,col) to
// the passing sum (cells at or past inner_count add nothing), so an in-range
// read holds the input stalled while the sum passes the chain and the read,
// multiply and add stages of the last cell, and until the result register
// is free. An out-of-range read answers with index_error set. The exact sum
// is rounded half up to Q16.16 and saturated to 32 bits, raising overflow
// when clipped. Stores are undefined until written. The result register
// lets the next write beat in while a result waits to be taken.
// ----------------------------------------------------------------------------
module dense_matrix_multiply_unit
   import dmm_pkg::*;
#(
   parameter int MAX_ROWS  = DMM_MAX_ROWS,
   parameter int MAX_INNER = DMM_MAX_INNER,
   parameter int MAX_COLS  = DMM_MAX_COLS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_opcode,
   input  logic [5:0]                   req_row_index,
   input  logic [4:0]                   req_col_index,
   input  logic signed [DMM_DATA_W-1:0] req_element_value,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [DMM_DATA_W-1:0] rsp_product_value,
   output logic                         rsp_overflow,
   output logic                         rsp_index_error,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [3:0]                   csr_paddr,
   input  logic [31:0]                  csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);

   localparam int IW    = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
   localparam int SUM_W = DMM_PROD_W + 1 + IW;
   localparam int RND_W = SUM_W - 16;
   localparam logic signed [SUM_W-1:0] HALF_LSB = SUM_W'(32768);

   // configuration
   logic [6:0]  row_count_ff;
   logic [5:0]  inner_count_ff;
   logic [5:0]  col_count_ff;
   logic        csr_wr;
   dmm_reg_type csr_reg;

   // control
   dmm_state_type  state_ff;
   dmm_state_type  state_in;
   dmm_opcode_type op;
   logic           req_acc;
   logic           read_ok;
   logic           left_ok;
   logic           right_ok;
   logic           out_free;
   logic           launch;
   logic           rsp_load;

   // write broadcast and token
   dmm_wr_type                   wr_ff;
   logic [5:0]                   wr_row_ff;
   logic [4:0]                   wr_col_ff;
   logic signed [DMM_DATA_W-1:0] wr_data_ff;
   logic                         tok_vld_ff;
   logic [5:0]                   tok_row_ff;
   logic [4:0]                   tok_col_ff;

   // result path
   logic                         sum_vld;
   logic signed [SUM_W-1:0]      sum;
   logic signed [SUM_W-1:0]      rnd_full;
   logic signed [RND_W-1:0]      rnd_ff;
   logic                         err_ff;
   logic                         fits;
   logic                         rsp_valid_ff;
   logic signed [DMM_DATA_W-1:0] product_ff;
   logic                         overflow_ff;
   logic                         index_error_ff;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_reg    = dmm_reg_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff   <= clamp_size(7'd64, MAX_ROWS);
         inner_count_ff <= 6'(clamp_size(7'd32, MAX_INNER));
         col_count_ff   <= 6'(clamp_size(7'd32, MAX_COLS));
      end else if (csr_wr) begin
         unique case (csr_reg)
            REG_ROW_COUNT: begin
               row_count_ff <= clamp_size(csr_pwdata[6:0], MAX_ROWS);
            end
            REG_INNER_COUNT: begin
               inner_count_ff <= 6'(clamp_size({1'b0, csr_pwdata[5:0]}, MAX_INNER));
            end
            REG_COL_COUNT: begin
               col_count_ff <= 6'(clamp_size({1'b0, csr_pwdata[5:0]}, MAX_COLS));
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_reg)
         REG_ROW_COUNT:   csr_prdata = {25'd0, row_count_ff};
         REG_INNER_COUNT: csr_prdata = {26'd0, inner_count_ff};
         REG_COL_COUNT:   csr_prdata = {26'd0, col_count_ff};
         default:         csr_prdata = 32'd0;
      endcase
   end

   // ---------------- input decode ----------------
   assign op       = dmm_opcode_type'(req_opcode);
   assign req_acc  = req_valid & ~req_stall;
   assign left_ok  = ({1'b0, req_row_index} < row_count_ff) &
                     ({1'b0, req_col_index} < inner_count_ff);
   assign right_ok = ({1'b0, req_row_index} < {1'b0, inner_count_ff}) &
                     ({1'b0, req_col_index} < col_count_ff);
   assign read_ok  = ({1'b0, req_row_index} < row_count_ff) &
                     ({1'b0, req_col_index} < col_count_ff);
   assign out_free = ~rsp_valid_ff | ~rsp_stall;

   // ---------------- state machine ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc && op == OP_READ) begin
               state_in = read_ok ? ST_RUN : ST_DONE;
            end
         end
         ST_RUN: begin
            if (sum_vld) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      launch    = (state_ff == ST_IDLE) & req_acc & (op == OP_READ) & read_ok;
      rsp_load  = (state_ff == ST_DONE) & out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------- write broadcast and token ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff      <= '0;
         tok_vld_ff <= 1'b0;
      end else begin
         wr_ff.left  <= req_acc & (op == OP_WRITE_LEFT) & left_ok;
         wr_ff.right <= req_acc & (op == OP_WRITE_RIGHT) & right_ok;
         tok_vld_ff  <= launch;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         wr_row_ff  <= req_row_index;
         wr_col_ff  <= req_col_index;
         wr_data_ff <= req_element_value;
         tok_row_ff <= req_row_index;
         tok_col_ff <= req_col_index;
      end
      if (req_acc && op == OP_READ) begin
         err_ff <= ~read_ok;
      end
   end

   dmm_chain #(
      .MAX_ROWS  (MAX_ROWS),
      .MAX_INNER (MAX_INNER),
      .MAX_COLS  (MAX_COLS),
      .SUM_W     (SUM_W)
   ) u_chain (
      .clock       (clock),
      .reset       (reset),
      .inner_count (inner_count_ff),
      .wr          (wr_ff),
      .wr_row      (wr_row_ff),
      .wr_col      (wr_col_ff),
      .wr_data     (wr_data_ff),
      .tok_vld     (tok_vld_ff),
      .tok_row     (tok_row_ff),
      .tok_col     (tok_col_ff),
      .sum_vld     (sum_vld),
      .sum         (sum)
   );

   // ---------------- round, saturate, result register ----------------
   // round half up, then floor to Q16.16
   assign rnd_full = sum + HALF_LSB;

   always_ff @(posedge clock) begin
      if (state_ff == ST_RUN && sum_vld) begin
         rnd_ff <= rnd_full[SUM_W-1:16];
      end
   end

   // fits in 32 bits when every bit from bit 31 up matches the sign
   assign fits = (&rnd_ff[RND_W-1:DMM_DATA_W-1]) | ~(|rnd_ff[RND_W-1:DMM_DATA_W-1]);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         if (err_ff) begin
            product_ff     <= '0;
            overflow_ff    <= 1'b0;
            index_error_ff <= 1'b1;
         end else begin
            index_error_ff <= 1'b0;
            overflow_ff    <= ~fits;
            if (fits) begin
               product_ff <= rnd_ff[DMM_DATA_W-1:0];
            end else if (rnd_ff[RND_W-1]) begin
               product_ff <= {1'b1, {(DMM_DATA_W-1){1'b0}}};
            end else begin
               product_ff <= {1'b0, {(DMM_DATA_W-1){1'b1}}};
            end
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_product_value = product_ff;
   assign rsp_overflow      = overflow_ff;
   assign rsp_index_error   = index_error_ff;

endmodule

>>> verif/dense_matrix_multiply_unit_test.sv
// ----------------------------------------------------------------------------
// dense_matrix_multiply_unit_test
// Self-checking bench for the dense Q16.16 matrix multiply unit.
// ----------------------------------------------------------------------------
// Beats from a queue load A and B elements and ask for C elements. Every
// accepted beat runs through a local model of the stores and the exact wide
// sum, which rounds and saturates the same way the unit should. Each product
// beat is checked field by field. Directed beats hit overflow in both
// directions, half-LSB rounding, dropped writes and out-of-range reads.
// Random phases then sweep several matrix sizes under sender gaps, receiver
// stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module dense_matrix_multiply_unit_test;
   import dmm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT   = 1_000_000;
   localparam int unsigned SETTLE_CYCLES = DMM_MAX_INNER + 8;
   localparam int unsigned LONG_HOLD     = 400;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct {
      dmm_opcode_type     op;
      logic [5:0]         row;
      logic [4:0]         col;
      logic signed [31:0] value;
   } matrix_beat_type;

   typedef struct {
      logic [31:0] product;
      logic        overflow;
      logic        index_error;
   } product_result_type;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [1:0]          req_opcode = OP_NOP;
   logic [5:0]          req_row_index = '0;
   logic [4:0]          req_col_index = '0;
   logic signed [31:0]  req_element_value = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic signed [31:0]  rsp_product_value;
   logic                rsp_overflow;
   logic                rsp_index_error;
   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic [3:0]          csr_paddr = '0;
   logic [31:0]         csr_pwdata = '0;
   logic [31:0]         csr_prdata;
   logic                csr_pready;

   dense_matrix_multiply_unit u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_row_index     (req_row_index),
      .req_col_index     (req_col_index),
      .req_element_value (req_element_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_product_value (rsp_product_value),
      .rsp_overflow      (rsp_overflow),
      .rsp_index_error   (rsp_index_error),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   // sizes as the unit sees them, shared by the predictor and the generator
   int unsigned cfg_rows  = DMM_MAX_ROWS;
   int unsigned cfg_inner = DMM_MAX_INNER;
   int unsigned cfg_cols  = DMM_MAX_COLS;

   logic signed [31:0] left_store  [DMM_MAX_ROWS][DMM_MAX_INNER];
   logic signed [31:0] right_store [DMM_MAX_INNER][DMM_MAX_COLS];
   bit                 left_loaded [DMM_MAX_ROWS][DMM_MAX_INNER];
   bit                 right_loaded[DMM_MAX_INNER][DMM_MAX_COLS];

   matrix_beat_type    pending_beats[$];
   product_result_type expected_products[$];
   matrix_beat_type    beat_on_bus;

   idle_mode_type idle_mode = IDLE_NONE;
   bit            hold_go = 1'b0;
   bit            hold_ack = 1'b0;
   int unsigned   hold_left = 0;

   int unsigned cycle_count = 0;
   int unsigned error_count = 0;
   int unsigned planned_beats = 0;
   int unsigned beats_accepted = 0;
   int unsigned products_checked = 0;
   int unsigned saturations_seen = 0;
   int unsigned range_errors_seen = 0;
   int unsigned settings_run = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d products still due",
                  cycle_count, expected_products.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   task automatic report_mismatch(string msg);
      $display("cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   function automatic int unsigned fit_size(int unsigned v, int unsigned top);
      if (v == 0) return 1;
      if (v > top) return top;
      return v;
   endfunction

   // stores update on writes in range; a read sums exact Q32.32 products
   function automatic void predict_beat(matrix_beat_type b);
      product_result_type res;
      logic signed [79:0] acc;
      logic signed [79:0] term_a;
      logic signed [79:0] term_b;
      logic signed [79:0] rounded;
      case (b.op)
         OP_WRITE_LEFT: begin
            if (b.row < cfg_rows && b.col < cfg_inner) left_store[b.row][b.col] = b.value;
         end
         OP_WRITE_RIGHT: begin
            if (b.row < cfg_inner && b.col < cfg_cols) right_store[b.row][b.col] = b.value;
         end
         OP_READ: begin
            res = '{product: '0, overflow: 1'b0, index_error: 1'b0};
            if (b.row >= cfg_rows || b.col >= cfg_cols) begin
               res.index_error = 1'b1;
            end else begin
               acc = '0;
               for (int j = 0; j < cfg_inner; j++) begin
                  term_a = left_store[b.row][j];
                  term_b = right_store[j][b.col];
                  acc = acc + term_a * term_b;
               end
               // half up, then floor back to Q16.16
               rounded = (acc + 80'sd32768) >>> 16;
               if (rounded > 80'sd2147483647) begin
                  res.product = 32'h7FFF_FFFF;
                  res.overflow = 1'b1;
               end else if (rounded < -80'sd2147483648) begin
                  res.product = 32'h8000_0000;
                  res.overflow = 1'b1;
               end else begin
                  res.product = rounded[31:0];
               end
            end
            expected_products.push_back(res);
         end
         default: ;
      endcase
   endfunction

   function automatic bit sender_idles();
      case (idle_mode)
         IDLE_SENDER: return $urandom_range(99) < 59;
         IDLE_BOTH:   return $urandom_range(99) < 11;
         default:     return 1'b0;
      endcase
   endfunction

   function automatic bit receiver_stalls();
      case (idle_mode)
         IDLE_RECEIVER: return $urandom_range(99) < 59;
         IDLE_BOTH:     return $urandom_range(99) < 11;
         default:       return 1'b0;
      endcase
   endfunction

   // request side: hold the beat while stalled, predict at acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_beat(beat_on_bus);
            beats_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_beats.size() != 0 && !sender_idles()) begin
               beat_on_bus = pending_beats.pop_front();
               req_valid         <= 1'b1;
               req_opcode        <= beat_on_bus.op;
               req_row_index     <= beat_on_bus.row;
               req_col_index     <= beat_on_bus.col;
               req_element_value <= beat_on_bus.value;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off, loaded whenever the sequencer flips hold_go
   always @(posedge clock) begin
      if (hold_go != hold_ack) begin
         hold_ack  <= hold_go;
         hold_left <= LONG_HOLD;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   task automatic check_product();
      product_result_type want;
      if (expected_products.size() == 0) begin
         report_mismatch($sformatf("unexpected product beat %h", rsp_product_value));
         return;
      end
      want = expected_products.pop_front();
      products_checked++;
      if (want.overflow) saturations_seen++;
      if (want.index_error) range_errors_seen++;
      if (rsp_product_value !== want.product)
         report_mismatch($sformatf("product_value %h, predicted %h",
                                   rsp_product_value, want.product));
      if (rsp_overflow !== want.overflow)
         report_mismatch($sformatf("overflow %b, predicted %b", rsp_overflow, want.overflow));
      if (rsp_index_error !== want.index_error)
         report_mismatch($sformatf("index_error %b, predicted %b",
                                   rsp_index_error, want.index_error));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) check_product();
         rsp_stall <= (hold_left != 0) || receiver_stalls();
      end
   end

   task automatic csr_write(dmm_reg_type idx, logic [31:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_ROW_COUNT:   cfg_rows  = fit_size(data & 32'h7F, DMM_MAX_ROWS);
         REG_INNER_COUNT: cfg_inner = fit_size(data & 32'h3F, DMM_MAX_INNER);
         REG_COL_COUNT:   cfg_cols  = fit_size(data & 32'h3F, DMM_MAX_COLS);
         default: ;
      endcase
   endtask

   task automatic set_sizes(logic [31:0] rows, logic [31:0] inner, logic [31:0] cols);
      csr_write(REG_ROW_COUNT, rows);
      csr_write(REG_INNER_COUNT, inner);
      csr_write(REG_COL_COUNT, cols);
      settings_run++;
      @(negedge clock);
   endtask

   task automatic wait_for_drain();
      do @(negedge clock);
      while (pending_beats.size() != 0 || req_valid || expected_products.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // queue one beat and track which store entries the unit will hold
   task automatic push_beat(dmm_opcode_type op, int unsigned row, int unsigned col,
                            logic [31:0] value);
      matrix_beat_type b;
      b.op    = op;
      b.row   = row[5:0];
      b.col   = col[4:0];
      b.value = value;
      pending_beats.push_back(b);
      case (op)
         OP_WRITE_LEFT: begin
            if (b.row < cfg_rows && b.col < cfg_inner) begin
               left_loaded[b.row][b.col] = 1'b1;
               planned_beats++;
            end
         end
         OP_WRITE_RIGHT: begin
            if (b.row < cfg_inner && b.col < cfg_cols) begin
               right_loaded[b.row][b.col] = 1'b1;
               planned_beats++;
            end
         end
         OP_READ: planned_beats++;
         default: ;
      endcase
   endtask

   function automatic logic [31:0] pick_value();
      logic [31:0] v;
      case ($urandom_range(9))
         0, 1, 2: begin
            // within about +-8.0 so sums stay unsaturated
            v = $urandom_range(0, 32'h000F_FFFF);
            v = v - 32'h0008_0000;
         end
         3: begin
            case ($urandom_range(4))
               0: v = 32'h7FFF_FFFF;
               1: v = 32'h8000_0000;
               2: v = 32'h0000_0000;
               3: v = 32'h0000_0001;
               default: v = 32'hFFFF_FFFF;
            endcase
         end
         default: v = $urandom;
      endcase
      return v;
   endfunction

   // load whatever a row of A and a column of B still lack, then read
   task automatic plan_product_read();
      int unsigned r;
      int unsigned c;
      r = $urandom_range(cfg_rows - 1);
      c = $urandom_range(cfg_cols - 1);
      for (int j = 0; j < cfg_inner; j++) begin
         if (!left_loaded[r][j] || $urandom_range(7) == 0)
            push_beat(OP_WRITE_LEFT, r, j, pick_value());
         if (!right_loaded[j][c] || $urandom_range(7) == 0)
            push_beat(OP_WRITE_RIGHT, j, c, pick_value());
      end
      push_beat(OP_READ, r, c, $urandom);
   endtask

   task automatic plan_stray_read();
      bool_pick: begin
         if (cfg_rows < DMM_MAX_ROWS && (cfg_cols == DMM_MAX_COLS || $urandom_range(1))) begin
            push_beat(OP_READ, $urandom_range(DMM_MAX_ROWS - 1, cfg_rows),
                      $urandom_range(31), $urandom);
         end else if (cfg_cols < DMM_MAX_COLS) begin
            push_beat(OP_READ, $urandom_range(63),
                      $urandom_range(DMM_MAX_COLS - 1, cfg_cols), $urandom);
         end else begin
            plan_product_read();
         end
      end
   endtask

   task automatic plan_noise();
      dmm_opcode_type op;
      op = dmm_opcode_type'(2'($urandom_range(3)));
      if (op == OP_READ) plan_stray_read();
      else push_beat(op, $urandom_range(63), $urandom_range(31), pick_value());
   endtask

   task automatic run_phase(logic [31:0] rows, logic [31:0] inner, logic [31:0] cols,
                            idle_mode_type mode, int unsigned beats, bit long_hold);
      int unsigned goal;
      int unsigned sel;
      set_sizes(rows, inner, cols);
      idle_mode = mode;
      if (long_hold) hold_go = ~hold_go;
      goal = planned_beats + beats;
      while (planned_beats < goal) begin
         sel = $urandom_range(99);
         if (sel < 65) begin
            plan_product_read();
         end else if (sel < 80) begin
            if ($urandom_range(1))
               push_beat(OP_WRITE_LEFT, $urandom_range(cfg_rows - 1),
                         $urandom_range(cfg_inner - 1), pick_value());
            else
               push_beat(OP_WRITE_RIGHT, $urandom_range(cfg_inner - 1),
                         $urandom_range(cfg_cols - 1), pick_value());
         end else if (sel < 90) begin
            plan_stray_read();
         end else begin
            plan_noise();
         end
      end
      wait_for_drain();
   endtask

   initial begin : sequencer
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // sizes above the maximum clamp; a short inner sum keeps reads quick
      set_sizes(32'h7F, 32'd2, 32'h3F);
      csr_write(REG_UNUSED, 32'hFFFF_FFFF);
      push_beat(OP_WRITE_LEFT, 63, 0, 32'h7FFF_FFFF);
      push_beat(OP_WRITE_LEFT, 63, 1, 32'h7FFF_FFFF);
      push_beat(OP_WRITE_RIGHT, 0, 31, 32'h7FFF_FFFF);
      push_beat(OP_WRITE_RIGHT, 1, 31, 32'h7FFF_FFFF);
      push_beat(OP_READ, 63, 31, 32'hFFFF_FFFF);
      push_beat(OP_WRITE_RIGHT, 0, 31, 32'h8000_0000);
      push_beat(OP_WRITE_RIGHT, 1, 31, 32'h8000_0000);
      push_beat(OP_READ, 63, 31, 32'h0);
      // half an LSB rounds up, minus half rounds to zero
      push_beat(OP_WRITE_LEFT, 0, 0, 32'h0000_0001);
      push_beat(OP_WRITE_LEFT, 0, 1, 32'h0000_0000);
      push_beat(OP_WRITE_RIGHT, 0, 0, 32'h0000_8000);
      push_beat(OP_WRITE_RIGHT, 1, 0, 32'h0000_0000);
      push_beat(OP_READ, 0, 0, 32'h0);
      push_beat(OP_WRITE_LEFT, 0, 0, 32'hFFFF_FFFF);
      push_beat(OP_READ, 0, 0, 32'h0);
      // dropped writes past the inner size, and a no-op
      push_beat(OP_WRITE_LEFT, 0, 5, 32'h1234_5678);
      push_beat(OP_WRITE_RIGHT, 5, 0, 32'h1234_5678);
      push_beat(OP_NOP, 63, 31, 32'h5A5A_5A5A);
      push_beat(OP_READ, 0, 0, 32'h0);
      wait_for_drain();

      // zero sizes read as one
      set_sizes(32'd0, 32'd0, 32'd1);
      push_beat(OP_READ, 1, 0, 32'h0);
      push_beat(OP_READ, 0, 1, 32'h0);
      push_beat(OP_READ, 63, 31, 32'h0);
      push_beat(OP_WRITE_LEFT, 1, 0, 32'h7777_7777);
      push_beat(OP_WRITE_LEFT, 0, 0, 32'h0003_0000);
      push_beat(OP_WRITE_RIGHT, 0, 0, 32'hFFFE_0000);
      push_beat(OP_READ, 0, 0, 32'h0);
      wait_for_drain();

      run_phase(32'd64, 32'd32, 32'd32, IDLE_NONE, 250, 1'b0);
      run_phase(32'd5, 32'd3, 32'd4, IDLE_SENDER, 250, 1'b0);
      run_phase(32'd1, 32'd1, 32'd1, IDLE_RECEIVER, 150, 1'b0);
      run_phase(32'd17, 32'd8, 32'd9, IDLE_BOTH, 250, 1'b0);
      // the unit backs up behind a receiver that holds off for a long stretch
      run_phase(32'd100, 32'd40, 32'd33, IDLE_RECEIVER, 250, 1'b1);
      run_phase(32'd40, 32'd32, 32'd2, IDLE_BOTH, 250, 1'b0);

      if (expected_products.size() != 0)
         report_mismatch($sformatf("%0d predicted products never came",
                                   expected_products.size()));
      $display("covered %0d beats and %0d products over %0d size settings",
               beats_accepted, products_checked, settings_run);
      $display("%0d saturated sums, %0d out-of-range reads, %0d mismatches",
               saturations_seen, range_errors_seen, error_count);
      if (error_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

>>> dense_matrix_multiply_unit.f
rtl/core/dmm_pkg.sv
rtl/core/dmm_cell.sv
rtl/core/dmm_chain.sv
rtl/core/dense_matrix_multiply_unit.sv
verif/dense_matrix_multiply_unit_test.sv
